FILE: sv/olids_pkg.sv
// Shared constants, codes and the cell control bundle for the ordered list block.
`timescale 1ns / 1ps
package olids_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int MODE_W       = 2;
  localparam int LEN_W        = 11;
  localparam int CAPACITY_DEF = 128;
  localparam int LOC_GROUP    = 16;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [LEN_W-1:0]  pos0;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] val;
  } cell_ctl_t;

endpackage

FILE: sv/olids_cell.sv
// One list entry: shifts with its neighbors, compares against the key, offers its word on delete.
`timescale 1ns / 1ps
module olids_cell import olids_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic              match,
  output logic [DATA_W-1:0] pick
);

  localparam logic [LEN_W-1:0] MyIdx = LEN_W'(IDX);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              match_r;
  logic [DATA_W-1:0] pick_r;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_INS: begin
        if (MyIdx > ctl.pos0) begin
          data_nxt = left_data;
        end else if (MyIdx == ctl.pos0) begin
          data_nxt = ctl.val;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= ctl.pos0) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= (MyIdx < ctl.len) && (data_r == ctl.val);
    pick_r  <= (ctl.op == CELL_DEL && MyIdx == ctl.pos0) ? data_r : '0;
  end

  assign data  = data_r;
  assign match = match_r;
  assign pick  = pick_r;

endmodule

FILE: sv/olids_locate.sv
// Two-stage registered priority encoder that finds the first matching cell.
`timescale 1ns / 1ps
module olids_locate import olids_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic [CAPACITY-1:0] match_vec,
  output logic                found,
  output logic [POS_W-1:0]    found_pos
);

  localparam int NumGrp = (CAPACITY + LOC_GROUP - 1) / LOC_GROUP;
  localparam int GrpW   = $clog2(LOC_GROUP);
  localparam int PadW   = NumGrp * LOC_GROUP;
  localparam int SumW   = LEN_W + 1;

  logic [PadW-1:0]   padded;
  logic [NumGrp-1:0] grp_any_r;
  logic [GrpW-1:0]   grp_idx_r [NumGrp];
  logic [NumGrp-1:0] grp_any_nxt;
  logic [GrpW-1:0]   grp_idx_nxt [NumGrp];
  logic              found_r, found_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SumW-1:0]   pos_full;

  assign padded = PadW'(match_vec);

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_idx_nxt[g] = '0;
      for (int k = LOC_GROUP - 1; k >= 0; k--) begin
        if (padded[g*LOC_GROUP + k]) begin
          grp_any_nxt[g] = 1'b1;
          grp_idx_nxt[g] = GrpW'(k);
        end
      end
    end
  end

  always_comb begin
    found_nxt = 1'b0;
    pos_full  = '0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        found_nxt = 1'b1;
        pos_full  = SumW'(g * LOC_GROUP) + SumW'(grp_idx_r[g]) + SumW'(1);
      end
    end
    pos_nxt = found_nxt ? pos_full[POS_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    for (int g = 0; g < NumGrp; g++) begin
      grp_idx_r[g] <= grp_idx_nxt[g];
    end
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
  end

  assign found     = found_r;
  assign found_pos = pos_r;

endmodule

FILE: sv/ordered_list_insert_delete_search_top.sv
// Top level of the ordered list block: request sequencer, length count and the chain of cells.
`timescale 1ns / 1ps
// The block keeps an ordered list of up to CAPACITY signed 32-bit entries in a row of cells,
// one entry per cell, and answers every request beat with exactly one result beat. Each
// request passes through these steps from acceptance to a ready result: every cell shifts
// or compares at once, then the deleted word is gathered from the row while the first-match
// encoder takes its first stage, then the second encoder stage runs, and then the output
// register is loaded. A new request is taken as soon as the previous one has moved into the
// output register, and not before; while the result side has not taken the last result, the
// block waits in S_OUT. Insert and delete move all later entries at once. Positions are
// 1-based; found_position and count_after carry the low 8 bits of their values.
module ordered_list_insert_delete_search_top import olids_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_ok,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic [POS_W-1:0]         out_found_position,
  output logic [POS_W-1:0]         out_count_after
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GATHER,
    S_ENC,
    S_OUT
  } state_t;

  localparam logic [LEN_W-1:0] CapLen = LEN_W'(CAPACITY);

  state_t             state_r;
  logic [LEN_W-1:0]   len_r;
  logic [MODE_W-1:0]  mode_r;
  logic [LEN_W-1:0]   pos_r;
  logic [DATA_W-1:0]  val_r;
  logic               ok_r;
  logic [DATA_W-1:0]  removed_r;
  logic               out_valid_r;
  logic               out_ok_r;
  logic [DATA_W-1:0]  out_removed_r;
  logic [POS_W-1:0]   out_found_r;
  logic [POS_W-1:0]   out_count_r;

  cell_ctl_t          ctl;
  logic               ins_ok;
  logic               del_ok;
  logic [DATA_W-1:0]  cell_data [CAPACITY];
  logic [DATA_W-1:0]  cell_pick [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [DATA_W-1:0]  pick_or;
  logic               loc_found;
  logic [POS_W-1:0]   loc_pos;
  logic               is_locate;

  assign ins_ok = (pos_r >= LEN_W'(1)) && (pos_r <= len_r + LEN_W'(1)) && (len_r < CapLen);
  assign del_ok = (pos_r >= LEN_W'(1)) && (pos_r <= len_r);
  assign is_locate = (mode_r == MODE_LOCATE);

  always_comb begin
    ctl.op   = CELL_HOLD;
    ctl.pos0 = pos_r - LEN_W'(1);
    ctl.len  = len_r;
    ctl.val  = val_r;
    if (state_r == S_EXEC) begin
      if (mode_r == MODE_INSERT && ins_ok) begin
        ctl.op = CELL_INS;
      end else if (mode_r == MODE_DELETE && del_ok) begin
        ctl.op = CELL_DEL;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = val_r;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end
    olids_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .match      (match_vec[i]),
      .pick       (cell_pick[i])
    );
  end

  always_comb begin
    pick_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pick_or = pick_or | cell_pick[i];
    end
  end

  olids_locate #(.CAPACITY(CAPACITY)) u_locate (
    .clk       (clk),
    .match_vec (match_vec),
    .found     (loc_found),
    .found_pos (loc_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            pos_r   <= LEN_W'(in_position);
            val_r   <= in_value;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          ok_r <= 1'b0;
          case (mode_r)
            MODE_INSERT: begin
              if (ins_ok) begin
                len_r <= len_r + LEN_W'(1);
                ok_r  <= 1'b1;
              end
            end
            MODE_DELETE: begin
              if (del_ok) begin
                len_r <= len_r - LEN_W'(1);
                ok_r  <= 1'b1;
              end
            end
            MODE_CLEAR: begin
              len_r <= '0;
              ok_r  <= 1'b1;
            end
            default: ok_r <= 1'b0;
          endcase
          state_r <= S_GATHER;
        end
        S_GATHER: begin
          removed_r <= pick_or;
          state_r   <= S_ENC;
        end
        S_ENC: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_ok_r      <= is_locate ? loc_found : ok_r;
            out_removed_r <= removed_r;
            out_found_r   <= is_locate ? loc_pos : '0;
            out_count_r   <= len_r[POS_W-1:0];
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_removed_value  = out_removed_r;
  assign out_found_position = out_found_r;
  assign out_count_after    = out_count_r;

endmodule
